// ===== rtl/tls_pkg.sv =====
`default_nettype none

package tls_pkg;

    // Fixed sizes of the block.
    localparam int unsigned WAYS_MAX   = 4;
    localparam int unsigned WAY_W      = 2;
    localparam int unsigned WAYS_CNT_W = 3;
    localparam int unsigned TIME_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // Smallest and largest number of approaches served.
    localparam logic [WAYS_CNT_W-1:0] WAYS_LOW  = 3'd2;
    localparam logic [WAYS_CNT_W-1:0] WAYS_HIGH = 3'd4;

    // Register reset values.
    localparam logic [WAYS_CNT_W-1:0] NUM_WAYS_RST = 3'd2;
    localparam logic [TIME_W-1:0]     YELLOW_RST   = 8'd10;
    localparam logic [TIME_W-1:0]     GREEN_RST    = 8'd60;

    // Light color codes.
    typedef enum logic [1:0] {
        COLOR_GREEN  = 2'd0,
        COLOR_RED    = 2'd1,
        COLOR_YELLOW = 2'd2
    } t_color;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_WAYS = 3'd0,
        REG_YELLOW   = 3'd1,
        REG_GREEN_0  = 3'd2,
        REG_GREEN_1  = 3'd3,
        REG_GREEN_2  = 3'd4,
        REG_GREEN_3  = 3'd5
    } t_reg_idx;

    // Configuration seen by the phase logic.
    typedef struct packed {
        logic [WAYS_CNT_W-1:0]            num_ways;
        logic [TIME_W-1:0]                yellow_time;
        logic [WAYS_MAX-1:0][TIME_W-1:0]  green_time;
    } t_tls_cfg;

    // Sequencer state.
    typedef struct packed {
        t_color [WAYS_MAX-1:0] colors;
        logic [WAY_W-1:0]      active;
        logic [TIME_W-1:0]     countdown;
    } t_tls_state;

    // One result item.
    typedef struct packed {
        t_color [WAYS_MAX-1:0] lights;
        logic [WAY_W-1:0]      active_way;
        logic                  changed;
        logic [TIME_W-1:0]     ticks_left;
    } t_tls_result;

    // Color that follows the given one in the cycle.
    function automatic t_color next_color(input t_color c);
        t_color r;
        case (c)
            COLOR_GREEN:  r = COLOR_YELLOW;
            COLOR_YELLOW: r = COLOR_RED;
            default:      r = COLOR_GREEN;
        endcase
        return r;
    endfunction

    // Countdown load for a phase; a zero duration acts as one tick.
    function automatic logic [TIME_W-1:0] load_value(input logic [TIME_W-1:0] d);
        return (d == '0) ? '0 : d - 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tls_step.sv =====
`default_nettype none

module tls_step (
    input  var tls_pkg::t_tls_cfg    i_cfg,
    input  var tls_pkg::t_tls_state  i_state,
    input  wire logic                i_elapse,
    output tls_pkg::t_tls_state      o_state,
    output tls_pkg::t_tls_result     o_result
);
    import tls_pkg::*;

    logic [WAYS_CNT_W-1:0] ways;
    logic [WAY_W-1:0]      cur_way;
    logic [WAYS_CNT_W-1:0] inc_way;
    logic [WAY_W-1:0]      nxt_way;
    t_color                cur_color;
    logic                  changed;
    t_tls_state            st;

    // Clamp the number of served approaches into its legal range.
    always_comb begin
        if (i_cfg.num_ways < WAYS_LOW) begin
            ways = WAYS_LOW;
        end else if (i_cfg.num_ways > WAYS_HIGH) begin
            ways = WAYS_HIGH;
        end else begin
            ways = i_cfg.num_ways;
        end
    end

    // Round-robin successor of the active approach.
    assign cur_way   = i_state.active;
    assign cur_color = next_color(i_state.colors[cur_way]);
    assign inc_way   = {1'b0, cur_way} + 3'd1;
    assign nxt_way   = (inc_way >= ways) ? '0 : inc_way[WAY_W-1:0];

    // Phase advance on a tick.
    always_comb begin
        st      = i_state;
        changed = 1'b0;
        if (i_elapse) begin
            if (i_state.countdown == '0) begin
                changed             = 1'b1;
                st.colors[cur_way]  = cur_color;
                if (cur_color == COLOR_YELLOW) begin
                    st.countdown = load_value(i_cfg.yellow_time);
                end else if (cur_color == COLOR_RED) begin
                    // Hand the right of way to the next approach.
                    st.active          = nxt_way;
                    st.colors[nxt_way] = next_color(st.colors[nxt_way]);
                    st.countdown       = load_value(i_cfg.green_time[nxt_way]);
                end else begin
                    st.countdown = load_value(i_cfg.green_time[cur_way]);
                end
            end else begin
                st.countdown = i_state.countdown - 1'b1;
            end
        end
    end

    assign o_state = st;

    // Result fields; approaches not in use read red.
    always_comb begin
        for (int i = 0; i < WAYS_MAX; i++) begin
            o_result.lights[i] = (WAYS_CNT_W'(i) < ways) ? st.colors[i] : COLOR_RED;
        end
        o_result.active_way = st.active;
        o_result.changed    = changed;
        o_result.ticks_left = st.countdown;
    end

endmodule

`default_nettype wire

// ===== rtl/traffic_light_sequencer.sv =====
`default_nettype none

// Traffic light sequencer for one intersection of two to four approaches.
// Each transfer on the input channel carries one tick (elapse high) or a
// status request (elapse low) and produces exactly one result transfer with
// the four light colors, the approach holding right of way, a changed flag
// and the ticks left in the current phase. The phase logic sits between the
// state registers and the result register, and the input is ready whenever
// the result register is empty or being drained in the same cycle, so one
// item per cycle flows under no back pressure. Registers are written through
// the configuration channel, which is always ready; write them only while no
// result is outstanding.
module traffic_light_sequencer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_elapse,

    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_light_0,
    output logic [1:0]                         o_light_1,
    output logic [1:0]                         o_light_2,
    output logic [1:0]                         o_light_3,
    output logic [tls_pkg::WAY_W-1:0]          o_active_way,
    output logic                               o_changed,
    output logic [tls_pkg::TIME_W-1:0]         o_ticks_left,

    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tls_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tls_pkg::*;

    t_tls_cfg    r_cfg;
    t_tls_state  r_state;
    t_tls_state  n_state;
    t_tls_result n_result;
    t_tls_result r_result;
    logic        r_out_valid;
    logic        in_fire;
    logic        out_fire;
    logic        cfg_fire;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_ways    <= NUM_WAYS_RST;
            r_cfg.yellow_time <= YELLOW_RST;
            for (int i = 0; i < WAYS_MAX; i++) begin
                r_cfg.green_time[i] <= GREEN_RST;
            end
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                REG_NUM_WAYS: r_cfg.num_ways         <= i_cfg_data[WAYS_CNT_W-1:0];
                REG_YELLOW:   r_cfg.yellow_time      <= i_cfg_data;
                REG_GREEN_0:  r_cfg.green_time[0]    <= i_cfg_data;
                REG_GREEN_1:  r_cfg.green_time[1]    <= i_cfg_data;
                REG_GREEN_2:  r_cfg.green_time[2]    <= i_cfg_data;
                REG_GREEN_3:  r_cfg.green_time[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Phase logic.
    tls_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_elapse (i_elapse),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Sequencer state is updated on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WAYS_MAX; i++) begin
                r_state.colors[i] <= COLOR_RED;
            end
            r_state.active    <= '0;
            r_state.countdown <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_light_0    = r_result.lights[0];
    assign o_light_1    = r_result.lights[1];
    assign o_light_2    = r_result.lights[2];
    assign o_light_3    = r_result.lights[3];
    assign o_active_way = r_result.active_way;
    assign o_changed    = r_result.changed;
    assign o_ticks_left = r_result.ticks_left;

    // A tick with time left in the phase only counts down.
    a_no_change_mid_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_elapse && r_state.countdown != '0) |=> (o_out_valid && !o_changed))
        else $error("transition reported while countdown was running");

    // A tick at the end of a phase always makes a transition.
    a_change_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_elapse && r_state.countdown == '0) |=> (o_out_valid && o_changed))
        else $error("missing transition at end of phase");

    // A status request leaves the sequencer state untouched.
    a_status_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_elapse) |=> ($stable(r_state) && !o_changed))
        else $error("status request changed the state");

    // An empty result register never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// ===== sim/tls_checker.sv =====
`timescale 1ns / 100ps

// Watches the input, result and register channels of the sequencer, keeps its
// own copy of the intersection state and compares every result transfer with
// the oldest outstanding prediction.
module tls_checker (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_ready,
    input  wire logic                    i_elapse,

    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_ready,
    input  wire logic [1:0]              i_light_0,
    input  wire logic [1:0]              i_light_1,
    input  wire logic [1:0]              i_light_2,
    input  wire logic [1:0]              i_light_3,
    input  wire logic [1:0]              i_active_way,
    input  wire logic                    i_changed,
    input  wire logic [7:0]              i_ticks_left,

    input  wire logic                    i_cfg_valid,
    input  wire logic                    i_cfg_ready,
    input  wire logic [2:0]              i_cfg_index,
    input  wire logic [7:0]              i_cfg_data,

    output int                           o_fail_count,
    output int                           o_pending
);

    import tls_pkg::*;

    // Predicted register contents.
    logic [WAYS_CNT_W-1:0] cfg_num_ways;
    logic [TIME_W-1:0]     cfg_yellow;
    logic [TIME_W-1:0]     cfg_green [WAYS_MAX];

    // Predicted intersection state.
    t_color                way_color [WAYS_MAX];
    logic [WAY_W-1:0]      active_idx;
    logic [TIME_W-1:0]     phase_left;

    // Predicted results not yet seen on the result channel.
    t_tls_result           expected_lights [$];

    // Color shown after the given one.
    function automatic t_color color_after(input t_color c);
        t_color n;
        case (c)
            COLOR_GREEN: begin
                n = COLOR_YELLOW;
            end
            COLOR_YELLOW: begin
                n = COLOR_RED;
            end
            default: begin
                n = COLOR_GREEN;
            end
        endcase
        return n;
    endfunction

    // A phase of d ticks starts with d - 1 left; zero counts as one tick.
    function automatic logic [TIME_W-1:0] phase_start(input logic [TIME_W-1:0] d);
        return (d != 0) ? d - 1'b1 : '0;
    endfunction

    // Return to the state after reset.
    task automatic clear_intersection();
        int i;
        cfg_num_ways = NUM_WAYS_RST;
        cfg_yellow   = YELLOW_RST;
        for (i = 0; i < WAYS_MAX; i++) begin
            cfg_green[i] = GREEN_RST;
            way_color[i] = COLOR_RED;
        end
        active_idx = '0;
        phase_left = '0;
        expected_lights.delete();
    endtask

    // Apply one tick or status request and work out the result it produces.
    task automatic advance_intersection(input logic tick, output t_tls_result res);
        int unsigned served;
        int unsigned way;
        int          i;
        t_color      c;
        logic        changed;
        if (cfg_num_ways < WAYS_LOW) begin
            served = WAYS_LOW;
        end else if (cfg_num_ways > WAYS_HIGH) begin
            served = WAYS_HIGH;
        end else begin
            served = cfg_num_ways;
        end
        changed = 1'b0;
        if (tick) begin
            if (phase_left == 0) begin
                way = active_idx;
                c = color_after(way_color[way]);
                way_color[way] = c;
                changed = 1'b1;
                if (c == COLOR_YELLOW) begin
                    phase_left = phase_start(cfg_yellow);
                end else begin
                    // On red, right of way passes to the next approach in turn.
                    if (c == COLOR_RED) begin
                        way = (way + 1 >= served) ? 0 : way + 1;
                        active_idx = way[WAY_W-1:0];
                        way_color[way] = color_after(way_color[way]);
                    end
                    phase_left = phase_start(cfg_green[way]);
                end
            end else begin
                phase_left = phase_left - 1'b1;
            end
        end
        // Approaches outside the served set always show red.
        for (i = 0; i < WAYS_MAX; i++) begin
            res.lights[i] = (i < served) ? way_color[i] : COLOR_RED;
        end
        res.active_way = active_idx;
        res.changed    = changed;
        res.ticks_left = phase_left;
    endtask

    // Record and report one failure.
    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        $error("%s: expected %0d, actual %0d", field, want, got);
        o_fail_count++;
    endtask

    // Compare one result transfer with the oldest prediction.
    task automatic check_result();
        t_tls_result want;
        logic [1:0]  got_light [WAYS_MAX];
        int          i;
        if (expected_lights.size() == 0) begin
            $error("result transfer with no prediction outstanding");
            o_fail_count++;
        end else begin
            want = expected_lights.pop_front();
            got_light = '{i_light_0, i_light_1, i_light_2, i_light_3};
            for (i = 0; i < WAYS_MAX; i++) begin
                if (want.lights[i] !== got_light[i]) begin
                    note_mismatch($sformatf("light_%0d", i), want.lights[i], got_light[i]);
                end
            end
            if (want.active_way !== i_active_way) begin
                note_mismatch("active_way", want.active_way, i_active_way);
            end
            if (want.changed !== i_changed) begin
                note_mismatch("changed", want.changed, i_changed);
            end
            if (want.ticks_left !== i_ticks_left) begin
                note_mismatch("ticks_left", want.ticks_left, i_ticks_left);
            end
        end
    endtask

    // Update the register copy on a register write transfer.
    task automatic store_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_NUM_WAYS: begin
                cfg_num_ways = data[WAYS_CNT_W-1:0];
            end
            REG_YELLOW: begin
                cfg_yellow = data;
            end
            REG_GREEN_0: begin
                cfg_green[0] = data;
            end
            REG_GREEN_1: begin
                cfg_green[1] = data;
            end
            REG_GREEN_2: begin
                cfg_green[2] = data;
            end
            REG_GREEN_3: begin
                cfg_green[3] = data;
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Sample all channels at the rising edge; results leave before new items
    // enter, and a step sees the registers as they were before the edge.
    always @(posedge i_clk) begin : watch
        t_tls_result res;
        if (!i_rst_n) begin
            clear_intersection();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                advance_intersection(i_elapse, res);
                expected_lights = {expected_lights, res};
            end
            if (i_cfg_valid && i_cfg_ready) begin
                store_register(i_cfg_index, i_cfg_data);
            end
        end
        o_pending = expected_lights.size();
    end

endmodule

// ===== sim/tb_traffic_light_sequencer.sv =====
`timescale 1ns / 100ps

// Drives ticks and register writes into the sequencer under several idling
// patterns and reports the verdict of the checker.
module tb_traffic_light_sequencer;

    import tls_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int HOLD_CYCLES     = 96;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  elapse    = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    wire logic             in_ready;
    wire logic             out_valid;
    wire logic [1:0]       light_0;
    wire logic [1:0]       light_1;
    wire logic [1:0]       light_2;
    wire logic [1:0]       light_3;
    wire logic [1:0]       active_way;
    wire logic             changed;
    wire logic [7:0]       ticks_left;
    wire logic             cfg_ready;

    int                    fail_count;
    int                    pending;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    hold_req = 0;
    int                    hold_left = 0;
    int unsigned           cycle_cnt = 0;

    traffic_light_sequencer dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_elapse     (elapse),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_light_0    (light_0),
        .o_light_1    (light_1),
        .o_light_2    (light_2),
        .o_light_3    (light_3),
        .o_active_way (active_way),
        .o_changed    (changed),
        .o_ticks_left (ticks_left),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    tls_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_elapse     (elapse),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_light_0    (light_0),
        .i_light_1    (light_1),
        .i_light_2    (light_2),
        .i_light_3    (light_3),
        .i_active_way (active_way),
        .i_changed    (changed),
        .i_ticks_left (ticks_left),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock with a 4 ns period.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Give up if the run does not complete within the cycle budget.
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(negedge clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item, idling first at random, and return after its transfer.
    // Valid is left high so that a following item keeps it up.
    task automatic send_item(input logic tick);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        elapse   <= tick;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // One register write transfer; valid stays high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Write all registers in index order, then release the channel.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] vals [6]);
        int r;
        for (r = REG_NUM_WAYS; r <= REG_GREEN_3; r++) begin
            write_reg(r[CFG_IDX_W-1:0], vals[r]);
        end
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly short phases so that transitions come often; a few long ones.
    function automatic logic [CFG_DATA_W-1:0] pick_time();
        return CFG_DATA_W'(($urandom_range(15) == 0) ? $urandom_range(255)
                                                     : $urandom_range(5));
    endfunction

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] vals [6];
        int phase;
        int n;

        // Hold reset low, then release it.
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Four approaches with short phases, zero durations included:
        // a status request, then a full round ending on approach 3 in yellow.
        program_regs('{8'd4, 8'd0, 8'd0, 8'd1, 8'd2, 8'd1});
        send_item(1'b0);
        repeat (9) send_item(1'b1);

        // Serve two approaches while approach 3 holds right of way; the upper
        // data bits of the approach count are ignored.
        drain();
        program_regs('{8'hFA, 8'd1, 8'd1, 8'd2, 8'd1, 8'd1});
        send_item(1'b0);
        repeat (5) send_item(1'b1);

        // Writes to indexes beyond the register set change nothing.
        drain();
        write_reg(3'd6, 8'hA5);
        write_reg(3'd7, 8'h5A);
        cfg_valid <= 1'b0;
        @(negedge clk);

        // Approach counts below and above the served range.
        program_regs('{8'd1, 8'd255, 8'd255, 8'd0, 8'd1, 8'd255});
        repeat (3) send_item(1'b1);
        send_item(1'b0);
        drain();
        program_regs('{8'd7, 8'd2, 8'd1, 8'd2, 8'd3, 8'd1});
        repeat (4) send_item(1'b1);

        // Random phases cycling through the idling patterns.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            if (phase == 1) begin
                vals = '{8'd5, 8'd255, 8'd255, 8'd1, 8'd0, 8'd255};
            end else begin
                vals[REG_NUM_WAYS] = CFG_DATA_W'($urandom_range(255));
                for (n = REG_YELLOW; n <= REG_GREEN_3; n++) begin
                    vals[n] = pick_time();
                end
            end
            program_regs(vals);
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default: begin
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                end
            endcase
            // Hold the result side off while items keep coming, so the block
            // fills up and stops accepting input.
            if (phase == 4) begin
                hold_req = HOLD_CYCLES;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item($urandom_range(99) < 80);
                // Halfway through the first phase, pause until every result has come back.
                if (n == ITEMS_PER_PHASE / 2 && phase == 0) begin
                    drain();
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
